/* rtl/bitmap_page_allocator_unit_assert.svh */
// Assertion macros for the bitmap page allocator.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef BITMAP_PAGE_ALLOCATOR_UNIT_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define BPA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bpa assertion failed");
`define BPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bpa assertion failed");
`else
`define BPA_ASSERT(lbl, prop)
`define BPA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/bpa_pkg.sv */
// Shared constants, codes and command/status types of the page allocator.
// No dependencies.
package bpa_pkg;

  localparam int PoolPages = 4096;
  localparam int MapRows   = PoolPages / 8;
  localparam int RowAw     = $clog2(MapRows);
  localparam int IdxW      = $clog2(PoolPages);
  localparam int MaxRun    = 16;
  localparam int CntW      = 5;
  localparam int DirSlots  = 1024;
  localparam int DirRows   = DirSlots / 8;
  localparam int DirAw     = $clog2(DirRows);
  localparam int CfgW      = 14;

  localparam logic [CfgW-1:0] TotalReset    = 14'd8192;
  localparam logic [CfgW-1:0] ReservedPages = 14'd512;
  localparam logic [19:0]     ReservedFrame = 20'd512;
  localparam logic [19:0]     HeapVpage     = 20'hC0100;
  localparam logic [DirAw-1:0] DirRowLow    = DirAw'(768 / 8);
  localparam logic [DirAw-1:0] DirRowHigh   = DirAw'(1023 / 8);
  localparam logic [7:0]      DirBitsLow    = 8'h01;
  localparam logic [7:0]      DirBitsHigh   = 8'h80;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_RUN   = 2'd1,
    ST_NO_FRAME = 2'd2,
    ST_USER     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_SCAN_INIT,
    OP_SCAN_RD,
    OP_SCAN_EV,
    OP_MARK_RD,
    OP_MARK_WR,
    OP_DIR_RD,
    OP_DIR_WR,
    OP_RES_OK,
    OP_RES_FAIL
  } dp_op_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_VRD,
    S_VEV,
    S_MRD,
    S_MWR,
    S_PAGE,
    S_FRD,
    S_FEV,
    S_DRD,
    S_DEV,
    S_TRD,
    S_TEV,
    S_DWR,
    S_OK,
    S_FAIL
  } state_e;

  typedef struct packed {
    dp_op_e  op;
    logic    map_frame;
    logic    tbl;
    status_e st;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic pool;
    logic cnt_bad;
    logic row_end;
    logic found;
    logic m_last;
    logic idx_last;
    logic dir_present;
  } sts_t;

endpackage

/* rtl/bitmap_page_allocator_unit.sv */
// Kernel page allocator over a virtual bitmap, a frame bitmap and a directory map.
// Usage: s_axis carries one request word: tuser = pool_select, tdata[4:0] = page_count.
// m_axis gives one result word per mapped page, or a failure word last; tlast marks the final word.
// m_axis tdata from bit 0 up: virt_page[19:0], phys_page[39:20], table_new[40],
// table_page[60:41], status[62:61], zero[63].
// cfg_we_i writes total_pages from cfg_wdata_i; the new value is used at once, even mid-request.
// After reset a clearing pass zeroes all three maps but for directory slots 768 and
// 1023, which it marks present; no request is taken then. One request is worked at a
// time. The virtual run search reads the virtual map one 8-bit row at a time, up to
// (total_pages - 512) / 16 rows and at most 512. Marking reads and then writes back the
// virtual row of each page. Each frame search starts at the first row that may hold a
// free frame; the directory check reads the directory row, and a page-table frame takes
// another search. S_FAIL registers the result of a rejected request once the output
// register is free, and S_IDLE then takes the next request. A result waits in the
// output register while the receiver stalls, and the block holds further work until that
// word is taken; a new request is accepted once the final result is registered.
module bitmap_page_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [13:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // page_count[4:0], zero[7:5]
  input  logic        s_axis_tuser_i,  // pool_select[0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,  // virt, phys, table_new, table_page, status
  output logic        m_axis_tlast_o
);
  import bpa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bpa_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  bpa_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .page_count_i  (s_axis_tdata_i[4:0]),
    .pool_select_i (s_axis_tuser_i),
    .m_tdata_o     (m_axis_tdata_o),
    .m_tlast_o     (m_axis_tlast_o)
  );

`include "bitmap_page_allocator_unit_assert.svh"

  `BPA_ASSERT_NEXT(a_one_request, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)
  `BPA_ASSERT(a_mid_ok, (m_axis_tvalid_o && !m_axis_tlast_o) |-> (m_axis_tdata_o[62:61] == ST_OK))
  `BPA_ASSERT(a_table_zero, (m_axis_tvalid_o && !m_axis_tdata_o[40]) |-> (m_axis_tdata_o[60:41] == '0))

endmodule

/* rtl/bpa_ctrl.sv */
// Controller state machine of the page allocator.
// Depends on bpa_pkg; drives commands to bpa_datapath.
module bpa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  input  bpa_pkg::sts_t sts_i,
  output bpa_pkg::cmd_t cmd_o
);
  import bpa_pkg::*;

  state_e  state_q, state_d;
  status_e fail_q, fail_d;
  logic    mvalid_q, mvalid_d;
  logic    out_free;

  assign out_free = !mvalid_q || m_axis_tready_i;

  always_comb begin
    state_d = state_q;
    fail_d  = fail_q;
    unique case (state_q)
      S_CLEAR: if (sts_i.clear_last) state_d = S_IDLE;
      S_IDLE:  if (s_axis_tvalid_i) state_d = S_CHECK;
      S_CHECK: begin
        if (sts_i.pool) begin
          fail_d  = ST_USER;
          state_d = S_FAIL;
        end else if (sts_i.cnt_bad) begin
          fail_d  = ST_NO_RUN;
          state_d = S_FAIL;
        end else begin
          state_d = S_VRD;
        end
      end
      S_VRD: begin
        if (sts_i.row_end) begin
          fail_d  = ST_NO_RUN;
          state_d = S_FAIL;
        end else begin
          state_d = S_VEV;
        end
      end
      S_VEV:   state_d = sts_i.found ? S_MRD : S_VRD;
      S_MRD:   state_d = S_MWR;
      S_MWR:   state_d = sts_i.m_last ? S_PAGE : S_MRD;
      S_PAGE:  state_d = S_FRD;
      S_FRD: begin
        if (sts_i.row_end) begin
          fail_d  = ST_NO_FRAME;
          state_d = S_FAIL;
        end else begin
          state_d = S_FEV;
        end
      end
      S_FEV:   state_d = sts_i.found ? S_DRD : S_FRD;
      S_DRD:   state_d = S_DEV;
      S_DEV:   state_d = sts_i.dir_present ? S_OK : S_TRD;
      S_TRD: begin
        if (sts_i.row_end) begin
          fail_d  = ST_NO_FRAME;
          state_d = S_FAIL;
        end else begin
          state_d = S_TEV;
        end
      end
      S_TEV:   state_d = sts_i.found ? S_DWR : S_TRD;
      S_DWR:   state_d = S_OK;
      S_OK: begin
        if (out_free) state_d = sts_i.idx_last ? S_IDLE : S_PAGE;
      end
      S_FAIL:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.op        = OP_NONE;
    cmd_o.st        = fail_q;
    s_axis_tready_o = 1'b0;
    mvalid_d        = mvalid_q && !m_axis_tready_i;
    unique case (state_q)
      S_CLEAR: cmd_o.op = OP_CLEAR;
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) cmd_o.op = OP_LOAD;
      end
      S_CHECK: cmd_o.op = (sts_i.pool || sts_i.cnt_bad) ? OP_NONE : OP_SCAN_INIT;
      S_VRD, S_FRD, S_TRD: cmd_o.op = sts_i.row_end ? OP_NONE : OP_SCAN_RD;
      S_VEV: cmd_o.op = OP_SCAN_EV;
      S_FEV: begin
        cmd_o.op        = OP_SCAN_EV;
        cmd_o.map_frame = 1'b1;
      end
      S_TEV: begin
        cmd_o.op        = OP_SCAN_EV;
        cmd_o.map_frame = 1'b1;
        cmd_o.tbl       = 1'b1;
      end
      S_MRD: cmd_o.op = OP_MARK_RD;
      S_MWR: cmd_o.op = OP_MARK_WR;
      S_PAGE: begin
        cmd_o.op        = OP_SCAN_INIT;
        cmd_o.map_frame = 1'b1;
      end
      S_DRD: cmd_o.op = OP_DIR_RD;
      S_DEV: begin
        if (!sts_i.dir_present) begin
          cmd_o.op        = OP_SCAN_INIT;
          cmd_o.map_frame = 1'b1;
          cmd_o.tbl       = 1'b1;
        end
      end
      S_DWR: cmd_o.op = OP_DIR_WR;
      S_OK: begin
        if (out_free) begin
          cmd_o.op = OP_RES_OK;
          mvalid_d = 1'b1;
        end
      end
      S_FAIL: begin
        if (out_free) begin
          cmd_o.op = OP_RES_FAIL;
          mvalid_d = 1'b1;
        end
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

  assign m_axis_tvalid_o = mvalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      fail_q   <= ST_OK;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fail_q   <= fail_d;
      mvalid_q <= mvalid_d;
    end
  end

endmodule

/* rtl/bpa_datapath.sv */
// Datapath of the page allocator: bitmap memories, scan engine, result register.
// Depends on bpa_pkg; commanded by bpa_ctrl.
module bpa_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bpa_pkg::cmd_t             cmd_i,
  output bpa_pkg::sts_t             sts_o,
  input  logic                      cfg_we_i,
  input  logic [bpa_pkg::CfgW-1:0]  cfg_wdata_i,
  input  logic [bpa_pkg::CntW-1:0]  page_count_i,
  input  logic                      pool_select_i,
  output logic [63:0]               m_tdata_o,
  output logic                      m_tlast_o
);
  import bpa_pkg::*;

  logic [7:0] virt_mem  [MapRows];
  logic [7:0] frame_mem [MapRows];
  logic [7:0] dir_mem   [DirRows];

  logic [7:0] virt_rd_q, frame_rd_q, dir_rd_q;

  logic [CfgW-1:0]  total_q;
  logic [RowAw-1:0] clr_q, hint_q;
  logic             pool_q, map_q, tbl_q;
  logic [CntW-1:0]  cnt_q, tgt_q, run_q, idx_q, m_q;
  logic [IdxW-1:0]  start_q;
  logic [RowAw:0]   row_q;
  logic [19:0]      pp_q, tp_q;
  logic             tn_q;
  logic [62:0]      res_q;
  logic             last_q;

  logic [CfgW-1:0]  free_pages;
  logic [RowAw:0]   rows_raw, len_rows;
  logic [7:0]       scan_rd;
  logic [CntW-1:0]  run_c;
  logic             found_c;
  logic [IdxW-1:0]  pos_c, mbit;
  logic [19:0]      vpage;
  logic [9:0]       slot;

  logic             virt_we, frame_we, dir_we;
  logic [RowAw-1:0] virt_wa, frame_wa, virt_ra, frame_ra;
  logic [DirAw-1:0] dir_wa;
  logic [7:0]       virt_wd, frame_wd, dir_wd;
  logic             virt_re, frame_re, dir_re;

  assign free_pages = (total_q > ReservedPages) ? total_q - ReservedPages : '0;
  assign rows_raw   = free_pages[CfgW-1:4];
  assign len_rows   = (rows_raw > (RowAw+1)'(MapRows)) ? (RowAw+1)'(MapRows) : rows_raw;

  assign scan_rd = map_q ? frame_rd_q : virt_rd_q;
  assign mbit    = start_q + IdxW'(m_q);
  assign vpage   = HeapVpage + 20'(start_q) + 20'(idx_q);
  assign slot    = vpage[19:10];

  always_comb begin
    run_c   = run_q;
    found_c = 1'b0;
    pos_c   = '0;
    for (int b = 0; b < 8; b++) begin
      if (!found_c) begin
        if (scan_rd[b]) begin
          run_c = '0;
        end else begin
          run_c = run_c + CntW'(1);
          if (run_c == tgt_q) begin
            found_c = 1'b1;
            pos_c   = {row_q[RowAw-1:0], 3'(b)} + IdxW'(1) - IdxW'(tgt_q);
          end
        end
      end
    end
  end

  always_comb begin
    sts_o.clear_last  = (clr_q == RowAw'(MapRows - 1));
    sts_o.pool        = pool_q;
    sts_o.cnt_bad     = (cnt_q == '0) || (cnt_q > CntW'(MaxRun));
    sts_o.row_end     = (row_q >= len_rows);
    sts_o.found       = found_c;
    sts_o.m_last      = (m_q == cnt_q - CntW'(1));
    sts_o.idx_last    = (idx_q == cnt_q - CntW'(1));
    sts_o.dir_present = dir_rd_q[slot[2:0]];
  end

  always_comb begin
    virt_we  = 1'b0;
    frame_we = 1'b0;
    dir_we   = 1'b0;
    virt_wa  = clr_q;
    frame_wa = clr_q;
    dir_wa   = clr_q[DirAw-1:0];
    virt_wd  = '0;
    frame_wd = '0;
    dir_wd   = '0;
    virt_re  = 1'b0;
    frame_re = 1'b0;
    dir_re   = 1'b0;
    virt_ra  = row_q[RowAw-1:0];
    frame_ra = row_q[RowAw-1:0];
    case (cmd_i.op)
      OP_CLEAR: begin
        virt_we  = 1'b1;
        frame_we = 1'b1;
        dir_we   = 1'b1;
        if (clr_q[DirAw-1:0] == DirRowLow) begin
          dir_wd = DirBitsLow;
        end else if (clr_q[DirAw-1:0] == DirRowHigh) begin
          dir_wd = DirBitsHigh;
        end
      end
      OP_SCAN_RD: begin
        virt_re  = !map_q;
        frame_re = map_q;
      end
      OP_SCAN_EV: begin
        if (found_c && map_q) begin
          frame_we = 1'b1;
          frame_wa = row_q[RowAw-1:0];
          frame_wd = frame_rd_q | (8'd1 << pos_c[2:0]);
        end
      end
      OP_MARK_RD: begin
        virt_re = 1'b1;
        virt_ra = mbit[IdxW-1:3];
      end
      OP_MARK_WR: begin
        virt_we = 1'b1;
        virt_wa = mbit[IdxW-1:3];
        virt_wd = virt_rd_q | (8'd1 << mbit[2:0]);
      end
      OP_DIR_RD: dir_re = 1'b1;
      OP_DIR_WR: begin
        dir_we = 1'b1;
        dir_wa = slot[9:3];
        dir_wd = dir_rd_q | (8'd1 << slot[2:0]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (virt_we) virt_mem[virt_wa] <= virt_wd;
    if (virt_re) virt_rd_q <= virt_mem[virt_ra];
  end

  always_ff @(posedge clk_i) begin
    if (frame_we) frame_mem[frame_wa] <= frame_wd;
    if (frame_re) frame_rd_q <= frame_mem[frame_ra];
  end

  always_ff @(posedge clk_i) begin
    if (dir_we) dir_mem[dir_wa] <= dir_wd;
    if (dir_re) dir_rd_q <= dir_mem[slot[9:3]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TotalReset;
      clr_q   <= '0;
      hint_q  <= '0;
    end else begin
      if (cfg_we_i) total_q <= cfg_wdata_i;
      if (cmd_i.op == OP_CLEAR) clr_q <= clr_q + RowAw'(1);
      if (cmd_i.op == OP_SCAN_EV && found_c && map_q) hint_q <= row_q[RowAw-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        pool_q <= pool_select_i;
        cnt_q  <= page_count_i;
        idx_q  <= '0;
      end
      OP_SCAN_INIT: begin
        map_q <= cmd_i.map_frame;
        tbl_q <= cmd_i.tbl;
        run_q <= '0;
        row_q <= cmd_i.map_frame ? {1'b0, hint_q} : '0;
        tgt_q <= cmd_i.map_frame ? CntW'(1) : cnt_q;
        if (cmd_i.map_frame && !cmd_i.tbl) begin
          pp_q <= '0;
          tp_q <= '0;
          tn_q <= 1'b0;
        end
      end
      OP_SCAN_EV: begin
        if (found_c) begin
          if (!map_q) begin
            start_q <= pos_c;
            m_q     <= '0;
          end else if (tbl_q) begin
            tp_q <= ReservedFrame + 20'(pos_c);
            tn_q <= 1'b1;
          end else begin
            pp_q <= ReservedFrame + 20'(pos_c);
          end
        end else begin
          row_q <= row_q + (RowAw+1)'(1);
          run_q <= run_c;
        end
      end
      OP_MARK_WR: m_q <= m_q + CntW'(1);
      OP_RES_OK: begin
        res_q  <= {ST_OK, tp_q, tn_q, pp_q, vpage};
        last_q <= sts_o.idx_last;
        idx_q  <= idx_q + CntW'(1);
      end
      OP_RES_FAIL: begin
        last_q <= 1'b1;
        if (cmd_i.st == ST_NO_FRAME) begin
          res_q <= {cmd_i.st, 20'd0, 1'b0, pp_q, vpage};
        end else begin
          res_q <= {cmd_i.st, 61'd0};
        end
      end
      default: ;
    endcase
  end

  assign m_tdata_o = {1'b0, res_q};
  assign m_tlast_o = last_q;

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for bitmap_page_allocator_unit: random and directed requests
// against a predictor of the kernel maps. Depends on bpa_pkg and the allocator RTL.
`timescale 1ns / 100ps

module tb_top;
  import bpa_pkg::*;

  localparam int WatchLimit = 200000;

  typedef struct packed {
    logic [63:0] word;
    logic        last;
  } alloc_word_t;

  class alloc_scoreboard;
    bit          frame_map [PoolPages];
    bit          virt_map [PoolPages];
    bit          dir_map [DirSlots];
    int unsigned total;
    alloc_word_t pending_q[$];
    int          errors;

    function new();
      foreach (frame_map[i]) frame_map[i] = 0;
      foreach (virt_map[i]) virt_map[i] = 0;
      foreach (dir_map[i]) dir_map[i] = 0;
      dir_map[768] = 1;
      dir_map[1023] = 1;
      total = TotalReset;
      errors = 0;
    endfunction

    function int unsigned map_len();
      int unsigned f;
      int unsigned k;
      f = (total > ReservedPages) ? total - ReservedPages : 0;
      k = ((f / 2) / 8) * 8;
      if (k > PoolPages) k = PoolPages;
      return k;
    endfunction

    function int lowest_run(bit frames, int unsigned len, int unsigned cnt);
      int unsigned run;
      bit          used;
      run = 0;
      for (int unsigned i = 0; i < len; i++) begin
        used = frames ? frame_map[i] : virt_map[i];
        if (used) begin
          run = 0;
        end else begin
          run++;
          if (run == cnt) return int'(i + 1 - cnt);
        end
      end
      return -1;
    endfunction

    function void push(logic [19:0] vp, logic [19:0] pp, logic tn, logic [19:0] tp,
                       status_e st, logic last);
      alloc_word_t e;
      e.word = {1'b0, st, tp, tn, pp, vp};
      e.last = last;
      pending_q.push_back(e);
    endfunction

    function void note_request(logic pool, logic [4:0] cnt);
      int unsigned len;
      int          start;
      int          b;
      int          t;
      logic [19:0] vp;
      int unsigned slot;
      len = map_len();
      if (pool) begin
        push(0, 0, 0, 0, ST_USER, 1);
        return;
      end
      if (cnt == 0 || cnt > MaxRun) begin
        push(0, 0, 0, 0, ST_NO_RUN, 1);
        return;
      end
      start = lowest_run(0, len, cnt);
      if (start < 0) begin
        push(0, 0, 0, 0, ST_NO_RUN, 1);
        return;
      end
      for (int i = 0; i < cnt; i++) virt_map[start + i] = 1;
      for (int i = 0; i < cnt; i++) begin
        vp = HeapVpage + 20'(start + i);
        slot = vp >> 10;
        b = lowest_run(1, len, 1);
        if (b < 0) begin
          push(vp, 0, 0, 0, ST_NO_FRAME, 1);
          return;
        end
        frame_map[b] = 1;
        if (!dir_map[slot]) begin
          t = lowest_run(1, len, 1);
          if (t < 0) begin
            push(vp, ReservedFrame + 20'(b), 0, 0, ST_NO_FRAME, 1);
            return;
          end
          frame_map[t] = 1;
          dir_map[slot] = 1;
          push(vp, ReservedFrame + 20'(b), 1, ReservedFrame + 20'(t), ST_OK, i + 1 == cnt);
        end else begin
          push(vp, ReservedFrame + 20'(b), 0, 0, ST_OK, i + 1 == cnt);
        end
      end
    endfunction

    function void check_word(logic [63:0] word, logic last);
      alloc_word_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected word expected none actual %h last %b", $time, word, last);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (word[19:0] !== e.word[19:0])
        $display("%0t: virt_page expected %h actual %h", $time, e.word[19:0], word[19:0]);
      if (word[39:20] !== e.word[39:20])
        $display("%0t: phys_page expected %h actual %h", $time, e.word[39:20], word[39:20]);
      if (word[40] !== e.word[40])
        $display("%0t: table_new expected %b actual %b", $time, e.word[40], word[40]);
      if (word[60:41] !== e.word[60:41])
        $display("%0t: table_page expected %h actual %h", $time, e.word[60:41], word[60:41]);
      if (word[62:61] !== e.word[62:61])
        $display("%0t: status expected %0d actual %0d", $time, e.word[62:61], word[62:61]);
      if (word[63] !== 1'b0)
        $display("%0t: pad bit expected 0 actual %b", $time, word[63]);
      if (last !== e.last)
        $display("%0t: last expected %b actual %b", $time, e.last, last);
      if (word !== e.word || last !== e.last) errors++;
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [13:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [63:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  alloc_scoreboard sb = new();
  int  hold_left = 0;
  bit  long_hold_req = 0;
  bit  out_stalls = 1;
  bit  in_gaps = 1;
  int  quiet_cycles = 0;

  bitmap_page_allocator_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o)
      sb.note_request(s_axis_tuser_i, s_axis_tdata_i[4:0]);
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_word(m_axis_tdata_o, m_axis_tlast_o);
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WatchLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (long_hold_req) begin
      long_hold_req = 0;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else if (out_stalls && $urandom_range(3) == 0) begin
      hold_left = ($urandom_range(9) == 0) ? $urandom_range(80, 20) : $urandom_range(2);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  task automatic send_request(logic pool, logic [4:0] cnt);
    int gap;
    gap = 0;
    if (in_gaps && $urandom_range(2) == 0)
      gap = ($urandom_range(9) == 0) ? $urandom_range(60, 10) : $urandom_range(3, 1);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= pool;
    s_axis_tdata_i <= {3'b000, cnt};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_total(logic [13:0] value);
    drain();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.total = value;
  endtask

  task automatic random_phase(logic [13:0] total, int items, bit big_runs);
    logic       pool;
    logic [4:0] cnt;
    write_total(total);
    in_gaps = $urandom_range(1);
    out_stalls = $urandom_range(1);
    for (int n = 0; n < items; n++) begin
      pool = ($urandom_range(15) == 0);
      if ($urandom_range(15) == 0)
        cnt = ($urandom_range(3) == 0) ? 5'd0 : 5'($urandom_range(31, 17));
      else if (big_runs && $urandom_range(1))
        cnt = 5'd16;
      else
        cnt = 5'($urandom_range(16, 1));
      if (n == items / 2) begin
        drain();
        in_gaps = ~in_gaps;
        out_stalls = ~out_stalls;
      end
      send_request(pool, cnt);
    end
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    out_stalls = 0;
    in_gaps = 0;
    send_request(1'b1, 5'd16);
    send_request(1'b1, 5'd0);
    send_request(1'b0, 5'd0);
    send_request(1'b0, 5'd17);
    send_request(1'b0, 5'd31);
    send_request(1'b0, 5'd1);
    send_request(1'b0, 5'd16);
    send_request(1'b0, 5'd2);
    out_stalls = 1;
    in_gaps = 1;
    send_request(1'b0, 5'd8);
    send_request(1'b0, 5'd15);
    write_total(14'd560);
    send_request(1'b0, 5'd16);
    send_request(1'b0, 5'd8);
    send_request(1'b0, 5'd1);
    write_total(14'd512);
    send_request(1'b0, 5'd1);
    send_request(1'b0, 5'd16);
    random_phase(14'd600, 40, 0);
    random_phase(14'd8192, 80, 0);
    long_hold_req = 1;
    random_phase(14'd8704, 300, 1);
    random_phase(14'd2000, 40, 0);
    drain();
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
